// File: rtl/core/reverse_cuthill_mckee_order_defines.svh
// Assertion macros for the reverse Cuthill-McKee ordering block
`ifndef REVERSE_CUTHILL_MCKEE_ORDER_DEFINES_SVH
`define REVERSE_CUTHILL_MCKEE_ORDER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcm same-cycle check failed");

// Next-cycle implication, checked out of reset
`define RCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcm next-cycle check failed");

`endif

// File: rtl/core/rcm_pkg.sv
// Shared types, codes and sizes for the reverse Cuthill-McKee ordering block
package rcm_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 16384;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;
  localparam logic [1:0] STAT_NO_RUN = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] node;
    logic [9:0] neighbor;
    logic [9:0] start_node;
    logic [9:0] position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  point_index;
    logic [10:0] max_queue_length;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_SET_ERR,
    OP_FILL_INIT,
    OP_FILL,
    OP_DEG_RD,
    OP_APPEND,
    OP_READ_ADDR,
    OP_READ_SET,
    OP_RUN_INIT,
    OP_SORT_RDI,
    OP_SORT_LATI,
    OP_SORT_RDJ,
    OP_SORT_CMP,
    OP_SORT_WR,
    OP_CLR_INIT,
    OP_VCLR,
    OP_START,
    OP_SCAN_RD,
    OP_SCAN_VRD,
    OP_CURSOR_INC,
    OP_PUSH_CAND,
    OP_DEQ_RD,
    OP_DEQ,
    OP_NB_INIT,
    OP_NB_RD,
    OP_NB_VRD,
    OP_NB_MARK,
    OP_INS_RD,
    OP_INS_SHIFT,
    OP_INS_PUT
  } dp_op_t;

  typedef enum logic [1:0] {
    OPX_NONE,
    OPX_PEAK,
    OPX_RUN_DONE,
    OPX_EMIT
  } dp_opx_t;

  typedef struct packed {
    dp_op_t  op;
    dp_opx_t opx;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       bad;
    logic       fill_done;
    logic       i_done;
    logic       j_done;
    logic       q_empty;
    logic       cursor_done;
    logic       vis_hit;
    logic       nb_out;
    logic       k_zero;
    logic       j_first;
    logic       shift;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/reverse_cuthill_mckee_order.sv
// An append first zeroes the degrees of nodes skipped since the last list.
// A run ranks the nodes and clears the visited flags, then walks the stored edges, shifting
// queue entries and marking visited nodes; the ranking loop dominates.
// One item is in flight at a time; the next is taken once the result is registered.
// Reset is synchronous: control state clears at once, with no clearing pass over the
// stores, since degrees above the highest listed node read as zero.
module reverse_cuthill_mckee_order #(
  parameter int MAX_NODES = rcm_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = rcm_pkg::MAX_EDGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rcm_pkg::out_item_t out_item
);
  import rcm_pkg::*;
  `include "reverse_cuthill_mckee_order_defines.svh"

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  rcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcm_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

  `RCM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RCM_ASSERT_NOW(a_no_run_no_peak, out_valid && out_item.status == STAT_NO_RUN, out_item.max_queue_length == 11'd0)
  `RCM_ASSERT_NOW(a_point_only_ok, out_valid && out_item.point_index != 10'd0, out_item.status == STAT_OK)

endmodule

// File: rtl/core/rcm_dp.sv
// Datapath of the ordering block: stores, counters, walk queue and result register
module rcm_dp #(
  parameter int MAX_NODES = rcm_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = rcm_pkg::MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [10:0]       cfg_data,
  input  rcm_pkg::in_item_t in_item,
  input  logic              out_stall,
  output logic              out_valid,
  output rcm_pkg::out_item_t out_item,
  input  rcm_pkg::ctl_cmd_t cmd,
  output rcm_pkg::dp_sts_t  sts
);
  import rcm_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);

  // stores
  logic [NW-1:0]   ns_mem   [MAX_EDGES];
  logic [EAW-1:0]  ls_mem   [MAX_NODES];
  logic [EW-1:0]   deg_mem  [MAX_NODES];
  logic [NW-1:0]   srt_mem  [MAX_NODES];
  logic [NW-1:0]   rank_mem [MAX_NODES];
  logic            vis_mem  [MAX_NODES];
  logic [2*NW-1:0] wq_mem   [MAX_NODES];

  // control and payload registers
  logic [10:0]    nodes;
  in_item_t       item;
  logic           any_list;
  logic [NW-1:0]  last_node;
  logic [EW-1:0]  edge_cnt;
  logic [CW-1:0]  peak;
  logic           ready;
  logic [CW-1:0]  run_len;
  logic [CW-1:0]  run_n;
  logic [1:0]     res_status;
  logic [NW-1:0]  res_point;
  logic [CW-1:0]  i, j, cnt, head, tail, first, cursor;
  logic [EW-1:0]  di;
  logic [EAW-1:0] e;
  logic [EW-1:0]  k_left;
  logic [NW-1:0]  nb, nbr, cand;

  // registered read data
  logic [NW-1:0]   ns_q;
  logic [EAW-1:0]  ls_q;
  logic [EW-1:0]   deg_rd;
  logic            deg_gate;
  logic [NW-1:0]   srt_q;
  logic [NW-1:0]   rank_q;
  logic            vis_q;
  logic [2*NW-1:0] wq_q;

  logic [CW-1:0] n_eff;
  logic [EW-1:0] deg_q;
  logic [1:0]    err_code;
  logic [NW-1:0] node_i, nbor_i, start_i;
  logic [CW-1:0] rev_pos;

  // memory ports
  logic            ns_we;
  logic [EAW-1:0]  ns_wa, ns_ra;
  logic            ls_we;
  logic [NW-1:0]   ls_wa, ls_ra;
  logic            deg_we;
  logic [NW-1:0]   deg_wa, deg_ra;
  logic [EW-1:0]   deg_wd;
  logic            srt_we;
  logic [NW-1:0]   srt_wa, srt_ra;
  logic            rank_we;
  logic [NW-1:0]   rank_wa, rank_ra;
  logic            vis_we, vis_wd;
  logic [NW-1:0]   vis_wa, vis_ra;
  logic            wq_we;
  logic [NW-1:0]   wq_wa, wq_ra;
  logic [2*NW-1:0] wq_wd;

  always_comb begin
    if (32'(nodes) > 32'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(nodes);
    end
  end

  assign node_i  = NW'(item.node);
  assign nbor_i  = NW'(item.neighbor);
  assign start_i = NW'(item.start_node);
  assign deg_q   = deg_gate ? deg_rd : '0;
  assign rev_pos = run_len - CW'(1) - CW'(item.position);

  always_comb begin
    err_code = STAT_OK;
    case (item.command)
      CMD_APPEND: begin
        if (32'(item.node) >= 32'(n_eff) || 32'(item.neighbor) >= 32'(n_eff)) begin
          err_code = STAT_RANGE;
        end else if (any_list && last_node > node_i) begin
          err_code = STAT_RANGE;
        end else if (32'(edge_cnt) >= 32'(MAX_EDGES)) begin
          err_code = STAT_FULL;
        end
      end
      CMD_RUN: begin
        if (32'(item.start_node) >= 32'(n_eff)) begin
          err_code = STAT_RANGE;
        end
      end
      CMD_READ: begin
        if (!ready) begin
          err_code = STAT_NO_RUN;
        end else if (32'(item.position) >= 32'(run_len)) begin
          err_code = STAT_RANGE;
        end
      end
      default: err_code = STAT_OK;
    endcase
  end

  always_comb begin
    sts.command     = item.command;
    sts.bad         = (err_code != STAT_OK);
    sts.fill_done   = 32'(i) >= 32'(item.node);
    sts.i_done      = i >= run_n;
    sts.j_done      = j >= run_n;
    sts.q_empty     = head == tail;
    sts.cursor_done = cursor >= run_n;
    sts.vis_hit     = vis_q;
    sts.nb_out      = 32'(ns_q) >= 32'(run_n);
    sts.k_zero      = k_left == '0;
    sts.j_first     = j <= first;
    sts.shift       = wq_q[2*NW-1:NW] > nbr;
    sts.out_free    = !out_valid || !out_stall;
  end

  // memory address and write selection
  always_comb begin
    ns_we = 1'b0;   ns_wa = EAW'(edge_cnt);  ns_ra = e;
    ls_we = 1'b0;   ls_wa = node_i;          ls_ra = wq_q[NW-1:0];
    deg_we = 1'b0;  deg_wa = node_i;         deg_wd = deg_q + EW'(1);
    deg_ra = node_i;
    srt_we = 1'b0;  srt_wa = NW'(cnt);       srt_ra = NW'(cursor);
    rank_we = 1'b0; rank_wa = NW'(i);        rank_ra = ns_q;
    vis_we = 1'b0;  vis_wa = nb;             vis_wd = 1'b1;
    vis_ra = ns_q;
    wq_we = 1'b0;   wq_wa = NW'(j);          wq_wd = {nbr, nb};
    wq_ra = NW'(head);
    case (cmd.op)
      OP_FILL: begin
        deg_we = 1'b1;
        deg_wa = NW'(i);
        deg_wd = '0;
      end
      OP_APPEND: begin
        deg_we = 1'b1;
        ls_we  = (deg_q == '0);
        ns_we  = 1'b1;
      end
      OP_SORT_RDI: deg_ra = NW'(i);
      OP_SORT_RDJ: deg_ra = NW'(j);
      OP_DEQ:      deg_ra = wq_q[NW-1:0];
      OP_SORT_WR: begin
        srt_we  = 1'b1;
        rank_we = 1'b1;
      end
      OP_VCLR: begin
        vis_we = 1'b1;
        vis_wa = NW'(i);
        vis_wd = 1'b0;
      end
      OP_START: begin
        vis_we = 1'b1;
        vis_wa = start_i;
        wq_we  = 1'b1;
        wq_wa  = '0;
        wq_wd  = {{NW{1'b0}}, start_i};
      end
      OP_SCAN_VRD: vis_ra = srt_q;
      OP_PUSH_CAND: begin
        vis_we = 1'b1;
        vis_wa = cand;
        wq_we  = 1'b1;
        wq_wa  = NW'(tail);
        wq_wd  = {{NW{1'b0}}, cand};
      end
      OP_NB_MARK: vis_we = 1'b1;
      OP_INS_RD:  wq_ra = NW'(j - CW'(1));
      OP_INS_SHIFT: begin
        wq_we = 1'b1;
        wq_wd = wq_q;
      end
      OP_INS_PUT:   wq_we = 1'b1;
      OP_READ_ADDR: wq_ra = NW'(rev_pos);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ns_we) ns_mem[ns_wa] <= nbor_i;
    ns_q <= ns_mem[ns_ra];
  end

  always_ff @(posedge clk) begin
    if (ls_we) ls_mem[ls_wa] <= EAW'(edge_cnt);
    ls_q <= ls_mem[ls_ra];
  end

  always_ff @(posedge clk) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk) begin
    if (srt_we) srt_mem[srt_wa] <= NW'(i);
    srt_q <= srt_mem[srt_ra];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= NW'(cnt);
    rank_q <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (wq_we) wq_mem[wq_wa] <= wq_wd;
    wq_q <= wq_mem[wq_ra];
  end

  // degree entries above the highest listed node read as zero
  always_ff @(posedge clk) begin
    deg_gate <= any_list && (deg_ra <= last_node);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes     <= 11'd1;
      any_list  <= 1'b0;
      last_node <= '0;
      edge_cnt  <= '0;
      peak      <= '0;
      ready     <= 1'b0;
      run_len   <= '0;
      run_n     <= '0;
      out_valid <= 1'b0;
      i <= '0; j <= '0; cnt <= '0;
      head <= '0; tail <= '0; first <= '0; cursor <= '0;
      e <= '0; k_left <= '0;
    end else begin
      if (cfg_write) nodes <= cfg_data;
      if (out_valid && !out_stall && cmd.opx != OPX_EMIT) out_valid <= 1'b0;
      case (cmd.op)
        OP_LATCH: begin
          item       <= in_item;
          res_status <= STAT_OK;
          res_point  <= '0;
        end
        OP_CLEAR: begin
          any_list <= 1'b0;
          edge_cnt <= '0;
          ready    <= 1'b0;
          peak     <= '0;
        end
        OP_SET_ERR:   res_status <= err_code;
        OP_FILL_INIT: i <= any_list ? CW'(last_node) + CW'(1) : '0;
        OP_FILL:      i <= i + CW'(1);
        OP_APPEND: begin
          edge_cnt  <= edge_cnt + EW'(1);
          last_node <= node_i;
          any_list  <= 1'b1;
        end
        OP_READ_SET: res_point <= wq_q[NW-1:0];
        OP_RUN_INIT: begin
          run_n <= n_eff;
          i     <= '0;
        end
        OP_SORT_RDI: begin
          j   <= '0;
          cnt <= '0;
        end
        OP_SORT_LATI: di <= deg_q;
        OP_SORT_CMP: begin
          if (deg_q < di || (deg_q == di && j < i)) cnt <= cnt + CW'(1);
          j <= j + CW'(1);
        end
        OP_SORT_WR: i <= i + CW'(1);
        OP_CLR_INIT: begin
          i      <= '0;
          head   <= '0;
          tail   <= '0;
          cursor <= '0;
          peak   <= '0;
        end
        OP_VCLR:       i <= i + CW'(1);
        OP_START:      tail <= CW'(1);
        OP_SCAN_VRD:   cand <= srt_q;
        OP_CURSOR_INC: cursor <= cursor + CW'(1);
        OP_PUSH_CAND:  tail <= tail + CW'(1);
        OP_DEQ: begin
          head  <= head + CW'(1);
          first <= tail;
        end
        OP_NB_INIT: begin
          e      <= ls_q;
          k_left <= deg_q;
        end
        OP_NB_RD: begin
          e      <= e + EAW'(1);
          k_left <= k_left - EW'(1);
        end
        OP_NB_VRD: nb <= ns_q;
        OP_NB_MARK: begin
          nbr <= rank_q;
          j   <= tail;
        end
        OP_INS_SHIFT: j <= j - CW'(1);
        OP_INS_PUT:   tail <= tail + CW'(1);
        default: ;
      endcase
      case (cmd.opx)
        OPX_PEAK: begin
          if (tail - head > peak) peak <= tail - head;
        end
        OPX_RUN_DONE: begin
          run_len <= head;
          ready   <= 1'b1;
        end
        OPX_EMIT: begin
          out_valid                 <= 1'b1;
          out_item.status           <= res_status;
          out_item.point_index      <= 10'(res_point);
          out_item.max_queue_length <= 11'(peak);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/rcm_ctrl.sv
// Controller state machine that sequences loads, ranking, walk and reads
module rcm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcm_pkg::dp_sts_t  sts,
  output rcm_pkg::ctl_cmd_t cmd
);
  import rcm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_FILL, S_APP_RD, S_APP_WR, S_READ_WAIT,
    S_SORT_I, S_SORT_DI, S_SORT_J, S_SORT_CMP, S_CLR_INIT, S_CLR,
    S_START, S_TOP, S_SCAN, S_SCAN_V, S_SCAN_CHK, S_DEQ, S_DEQ_W,
    S_NB_INIT, S_NB_TOP, S_NB_CHK, S_NB_VCHK, S_INS_TOP, S_INS_CHK,
    S_DONE_RUN, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.opx    = OPX_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bad) begin
          cmd.op     = OP_SET_ERR;
          state_next = S_FINISH;
        end else begin
          case (sts.command)
            CMD_CLEAR: begin
              cmd.op     = OP_CLEAR;
              state_next = S_FINISH;
            end
            CMD_APPEND: begin
              cmd.op     = OP_FILL_INIT;
              state_next = S_FILL;
            end
            CMD_RUN: begin
              cmd.op     = OP_RUN_INIT;
              state_next = S_SORT_I;
            end
            default: begin
              cmd.op     = OP_READ_ADDR;
              state_next = S_READ_WAIT;
            end
          endcase
        end
      end
      // zero the degrees of nodes skipped since the last listed node
      S_FILL: begin
        if (sts.fill_done) begin
          cmd.op     = OP_DEG_RD;
          state_next = S_APP_RD;
        end else begin
          cmd.op = OP_FILL;
        end
      end
      S_APP_RD: state_next = S_APP_WR;
      S_APP_WR: begin
        cmd.op     = OP_APPEND;
        state_next = S_FINISH;
      end
      S_READ_WAIT: begin
        cmd.op     = OP_READ_SET;
        state_next = S_FINISH;
      end
      // rank each node by counting nodes that come before it
      S_SORT_I: begin
        if (sts.i_done) begin
          state_next = S_CLR_INIT;
        end else begin
          cmd.op     = OP_SORT_RDI;
          state_next = S_SORT_DI;
        end
      end
      S_SORT_DI: begin
        cmd.op     = OP_SORT_LATI;
        state_next = S_SORT_J;
      end
      S_SORT_J: begin
        if (sts.j_done) begin
          cmd.op     = OP_SORT_WR;
          state_next = S_SORT_I;
        end else begin
          cmd.op     = OP_SORT_RDJ;
          state_next = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        cmd.op     = OP_SORT_CMP;
        state_next = S_SORT_J;
      end
      S_CLR_INIT: begin
        cmd.op     = OP_CLR_INIT;
        state_next = S_CLR;
      end
      S_CLR: begin
        if (sts.i_done) begin
          state_next = S_START;
        end else begin
          cmd.op = OP_VCLR;
        end
      end
      S_START: begin
        cmd.op     = OP_START;
        state_next = S_TOP;
      end
      S_TOP: begin
        state_next = sts.q_empty ? S_SCAN : S_DEQ;
      end
      // restart from the lowest-ranked unvisited node
      S_SCAN: begin
        if (sts.cursor_done) begin
          state_next = S_DONE_RUN;
        end else begin
          cmd.op     = OP_SCAN_RD;
          state_next = S_SCAN_V;
        end
      end
      S_SCAN_V: begin
        cmd.op     = OP_SCAN_VRD;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.vis_hit) begin
          cmd.op     = OP_CURSOR_INC;
          state_next = S_SCAN;
        end else begin
          cmd.op     = OP_PUSH_CAND;
          state_next = S_DEQ;
        end
      end
      S_DEQ: begin
        cmd.op     = OP_DEQ_RD;
        state_next = S_DEQ_W;
      end
      S_DEQ_W: begin
        cmd.op     = OP_DEQ;
        state_next = S_NB_INIT;
      end
      S_NB_INIT: begin
        cmd.op     = OP_NB_INIT;
        state_next = S_NB_TOP;
      end
      S_NB_TOP: begin
        if (sts.k_zero) begin
          cmd.opx    = OPX_PEAK;
          state_next = S_TOP;
        end else begin
          cmd.op     = OP_NB_RD;
          state_next = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        if (sts.nb_out) begin
          state_next = S_NB_TOP;
        end else begin
          cmd.op     = OP_NB_VRD;
          state_next = S_NB_VCHK;
        end
      end
      S_NB_VCHK: begin
        if (sts.vis_hit) begin
          state_next = S_NB_TOP;
        end else begin
          cmd.op     = OP_NB_MARK;
          state_next = S_INS_TOP;
        end
      end
      // insert into this node's segment of the queue by rank
      S_INS_TOP: begin
        if (sts.j_first) begin
          cmd.op     = OP_INS_PUT;
          state_next = S_NB_TOP;
        end else begin
          cmd.op     = OP_INS_RD;
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.shift) begin
          cmd.op     = OP_INS_SHIFT;
          state_next = S_INS_TOP;
        end else begin
          cmd.op     = OP_INS_PUT;
          state_next = S_NB_TOP;
        end
      end
      S_DONE_RUN: begin
        cmd.opx    = OPX_RUN_DONE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.opx    = OPX_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: dv/tb_reverse_cuthill_mckee_order.sv
// Testbench for the reverse Cuthill-McKee ordering block: directed table, random graphs
`timescale 1ns / 1ps
module tb_reverse_cuthill_mckee_order;
  import rcm_pkg::*;

  localparam int NODES = 1024;
  localparam int EDGES = 16384;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    bit         is_cfg;
    logic [10:0] cfg;
    in_item_t   it;
    bit         typed;
    out_item_t  want;
  } step_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_write = 1'b0;
  logic [10:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // shadow of the block's state
  logic [9:0] nb_mem[EDGES];
  int         list_base[NODES + 1];
  int         degree[NODES];
  int         by_degree[NODES];
  int         rank_of[NODES];
  bit         seen[NODES];
  int         walk_q[NODES];
  int         order_mem[NODES];
  int         edges_used;
  int         peak_len;
  int         order_len;
  bit         order_valid;
  int         node_limit;

  out_item_t  pending_results[$];
  step_row_t  dir_rows[$];
  int         errors;
  int         burst_left;
  longint     cycles;
  int         stall_mode;
  int         stall_left;

  always #10 clk = ~clk;

  reverse_cuthill_mckee_order u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  function automatic out_item_t predict_order(in_item_t it);
    out_item_t r;
    int n, i, j, v, head, tail, visits, cursor, first, idx, nb, s;
    r = '0;
    n = (node_limit > NODES) ? NODES : node_limit;
    case (it.command)
      CMD_CLEAR: begin
        for (i = 0; i <= NODES; i++) list_base[i] = 0;
        for (i = 0; i < NODES; i++) degree[i] = 0;
        edges_used = 0;
        order_valid = 0;
        peak_len = 0;
      end
      CMD_APPEND: begin
        r.status = STAT_OK;
        if (it.node >= n || it.neighbor >= n) r.status = STAT_RANGE;
        for (i = int'(it.node) + 1; i < NODES && r.status == STAT_OK; i++)
          if (degree[i] != 0) r.status = STAT_RANGE;
        if (r.status == STAT_OK && edges_used >= EDGES) r.status = STAT_FULL;
        if (r.status == STAT_OK) begin
          if (degree[it.node] == 0) list_base[it.node] = edges_used;
          nb_mem[edges_used] = it.neighbor;
          edges_used++;
          degree[it.node]++;
          list_base[NODES] = edges_used;
        end
      end
      CMD_RUN: begin
        if (it.start_node >= n) begin
          r.status = STAT_RANGE;
        end else begin
          // stable sort by degree: ties stay in index order
          for (i = 0; i < n; i++) begin
            v = i;
            j = i;
            while (j > 0 && degree[by_degree[j - 1]] > degree[v]) begin
              by_degree[j] = by_degree[j - 1];
              j--;
            end
            by_degree[j] = v;
          end
          for (i = 0; i < n; i++) rank_of[by_degree[i]] = i;
          for (i = 0; i < NODES; i++) seen[i] = 0;
          cursor = 0;
          peak_len = 0;
          head = 0;
          tail = 0;
          visits = 0;
          seen[it.start_node] = 1;
          walk_q[tail++] = it.start_node;
          while (1) begin
            if (head == tail) begin
              while (cursor < n && seen[by_degree[cursor]]) cursor++;
              if (cursor >= n) break;
              seen[by_degree[cursor]] = 1;
              walk_q[tail++] = by_degree[cursor];
            end
            idx = walk_q[head++];
            order_mem[visits++] = idx;
            first = tail;
            s = list_base[idx];
            for (i = 0; i < degree[idx]; i++) begin
              if (s + i >= EDGES) break;
              nb = nb_mem[s + i];
              if (nb >= n || seen[nb]) continue;
              seen[nb] = 1;
              j = tail;
              while (j > first && rank_of[walk_q[j - 1]] > rank_of[nb]) begin
                walk_q[j] = walk_q[j - 1];
                j--;
              end
              walk_q[j] = nb;
              tail++;
            end
            if (tail - head > peak_len) peak_len = tail - head;
          end
          order_len = visits;
          order_valid = 1;
        end
      end
      default: begin
        if (!order_valid) r.status = STAT_NO_RUN;
        else if (it.position >= order_len) r.status = STAT_RANGE;
        else r.point_index = 10'(order_mem[order_len - 1 - it.position]);
      end
    endcase
    r.max_queue_length = 11'(peak_len);
    return r;
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, int a, int b);
    in_item_t it;
    it = '0;
    it.command = cmd;
    it.node = 10'(a);
    it.neighbor = 10'(b);
    it.start_node = 10'(a);
    it.position = 10'(a);
    // fill the unused fields with noise
    if (cmd != CMD_APPEND) begin
      it.node = 10'($urandom);
      it.neighbor = 10'($urandom);
    end
    if (cmd != CMD_RUN) it.start_node = 10'($urandom);
    if (cmd != CMD_READ) it.position = 10'($urandom);
    return it;
  endfunction

  function automatic step_row_t row(logic [1:0] cmd, int a, int b, bit typed,
                                    logic [1:0] st, int pt, int mq);
    step_row_t r;
    r.is_cfg = 0;
    r.cfg = '0;
    r.it = make_item(cmd, a, b);
    r.typed = typed;
    r.want.status = st;
    r.want.point_index = 10'(pt);
    r.want.max_queue_length = 11'(mq);
    return r;
  endfunction

  function automatic step_row_t cfg_row(int v);
    step_row_t r;
    r = row(CMD_CLEAR, 0, 0, 0, STAT_OK, 0, 0);
    r.is_cfg = 1;
    r.cfg = 11'(v);
    return r;
  endfunction

  task automatic send_item(in_item_t it, bit typed = 0, out_item_t want = '0);
    out_item_t exp_r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    exp_r = predict_order(it);
    pending_results.push_back(typed ? want : exp_r);
    burst_left--;
  endtask

  // hold off until the block is idle, then write the node count
  task automatic set_node_count(int v);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= 11'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    node_limit = v;
  endtask

  task automatic random_graph(int n);
    int nd, k, deg_n, nb, reads;
    set_node_count(n);
    send_item(make_item(CMD_CLEAR, 0, 0));
    for (nd = 0; nd < n; nd++) begin
      deg_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
      for (k = 0; k < deg_n; k++) begin
        nb = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
        send_item(make_item(CMD_APPEND, nd, nb));
      end
      // occasional broken append: node behind the current list
      if (nd > 1 && $urandom_range(0, 9) == 0)
        send_item(make_item(CMD_APPEND, $urandom_range(0, nd - 1), $urandom_range(0, n - 1)));
    end
    if ($urandom_range(0, 3) == 0)
      send_item(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                          $urandom_range(0, 1023)));
    repeat ($urandom_range(1, 2)) begin
      send_item(make_item(CMD_RUN, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                              : $urandom_range(0, n - 1), 0));
      reads = $urandom_range(n / 2, n + 4);
      repeat (reads)
        send_item(make_item(CMD_READ, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                               : $urandom_range(0, n - 1), 0));
    end
  endtask

  // receiver stall pattern: free-running, random, or long holds
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_item);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_item.status);
        if (out_item.point_index !== exp_r.point_index)
          $display("%0t: point_index exp %0d got %0d", $time, exp_r.point_index,
                   out_item.point_index);
        if (out_item.max_queue_length !== exp_r.max_queue_length)
          $display("%0t: max_queue_length exp %0d got %0d", $time, exp_r.max_queue_length,
                   out_item.max_queue_length);
        if (out_item !== exp_r) errors++;
      end
    end
  end

  initial begin
    int i, n;
    step_row_t r;
    burst_left = 0;
    node_limit = 1;
    edges_used = 0;
    peak_len = 0;
    order_len = 0;
    order_valid = 0;
    for (i = 0; i <= NODES; i++) list_base[i] = 0;
    for (i = 0; i < NODES; i++) degree[i] = 0;

    // out of reset, single node
    dir_rows.push_back(row(CMD_READ, 0, 0, 1, STAT_NO_RUN, 0, 0));
    dir_rows.push_back(row(CMD_RUN, 1, 0, 1, STAT_RANGE, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 1, 0, 1, STAT_RANGE, 0, 0));
    dir_rows.push_back(row(CMD_RUN, 0, 0, 1, STAT_OK, 0, 0));
    dir_rows.push_back(row(CMD_READ, 0, 0, 1, STAT_OK, 0, 0));
    dir_rows.push_back(row(CMD_READ, 1023, 0, 1, STAT_RANGE, 0, 0));
    dir_rows.push_back(row(CMD_CLEAR, 0, 0, 1, STAT_OK, 0, 0));
    // full size: field extremes and out-of-order append
    dir_rows.push_back(cfg_row(1024));
    dir_rows.push_back(row(CMD_APPEND, 1023, 1023, 1, STAT_OK, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 5, 0, 1, STAT_RANGE, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 1023, 0, 1, STAT_OK, 0, 0));
    dir_rows.push_back(row(CMD_READ, 0, 0, 1, STAT_NO_RUN, 0, 0));
    dir_rows.push_back(cfg_row(2047));
    dir_rows.push_back(row(CMD_APPEND, 1023, 512, 1, STAT_OK, 0, 0));
    dir_rows.push_back(row(CMD_CLEAR, 0, 0, 1, STAT_OK, 0, 0));
    // empty graph
    dir_rows.push_back(cfg_row(0));
    dir_rows.push_back(row(CMD_RUN, 0, 0, 1, STAT_RANGE, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 0, 0, 1, STAT_RANGE, 0, 0));
    // small graph with stale neighbors, then read after lowering the count
    dir_rows.push_back(cfg_row(8));
    dir_rows.push_back(row(CMD_APPEND, 0, 7, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 0, 2, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 2, 1, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 2, 4, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_APPEND, 3, 5, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(6));
    dir_rows.push_back(row(CMD_RUN, 3, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, 5, 0, 0, 0, 0, 0));
    dir_rows.push_back(cfg_row(2));
    dir_rows.push_back(row(CMD_READ, 4, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_READ, 6, 0, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      if (r.is_cfg) set_node_count(r.cfg);
      else send_item(r.it, r.typed, r.want);
    end

    for (i = 0; i < 10; i++) begin
      case ($urandom_range(0, 5))
        0: n = 1;
        1: n = $urandom_range(40, 64);
        default: n = $urandom_range(2, 24);
      endcase
      random_graph(n);
    end
    random_graph(1);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
